@@ rtl/core/z_slice_resample_address_macros.svh @@
// Assertion macros for the Z slice resample address block.
// Used by the top-level RTL file in this folder; expects clk and rst_n in scope.
`ifndef Z_SLICE_RESAMPLE_ADDRESS_MACROS_SVH
`define Z_SLICE_RESAMPLE_ADDRESS_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ZSRA_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the following cycle
`define ZSRA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// antecedent implies consequent a fixed number of cycles later
`define ZSRA_ASSERT_DELAY(name, ante, n, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
        else $error(msg);

`endif

@@ rtl/core/zsra_pkg.sv @@
// Package for the Z slice resample address block: types, codes, defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package zsra_pkg;

    localparam int MAX_SLICES_DEF  = 256;
    localparam int MAX_ROW_LEN_DEF = 1024;
    localparam int MAX_ROWS_DEF    = 1024;

    localparam int INDEX_W = 28;
    localparam int XY_W    = 22;

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_MAP  = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        REG_NEW_Z_RES   = 2'd0,
        REG_X_POINTS    = 2'd1,
        REG_Y_POINTS    = 2'd2,
        REG_SLICE_COUNT = 2'd3
    } reg_idx_t;

    typedef struct packed {
        func_t       func;
        logic [8:0]  entry;
        logic [31:0] boundary_value;
        logic [15:0] dest_slice;
        logic [9:0]  row;
        logic [9:0]  column;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         source_plane;
        logic [INDEX_W-1:0] source_index;
        logic               beyond_top;
    } result_t;

    // word handed from cell to cell
    typedef struct packed {
        func_t              func;
        logic [8:0]         entry;
        logic [31:0]        bval;
        logic [47:0]        pos;      // dest_slice * new_z_res
        logic [48:0]        nxt;      // (dest_slice + 1) * new_z_res
        logic [INDEX_W-1:0] rowcol;   // row * x_points + column
        logic               beyond;
    } chain_word_t;

endpackage

`default_nettype wire

@@ rtl/core/zsra_cell.sv @@
// One cell of the boundary chain: holds one table entry, updates the word
// passing through. Depends on zsra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module zsra_cell #(
    parameter int IDX     = 0,
    parameter int PLANE_W = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [8:0]            slice_count,
    input  wire logic                  in_valid,
    input  wire zsra_pkg::chain_word_t in_word,
    input  wire logic [PLANE_W-1:0]    in_plane,
    output logic                       out_valid,
    output zsra_pkg::chain_word_t      out_word,
    output logic [PLANE_W-1:0]         out_plane
);
    import zsra_pkg::*;

    logic [31:0]        bound_reg;
    logic [31:0]        bound_next;
    logic               valid_reg;
    chain_word_t        word_reg;
    chain_word_t        word_next;
    logic [PLANE_W-1:0] plane_reg;
    logic [PLANE_W-1:0] plane_next;
    logic               hit;
    logic               searched;
    logic               is_top;

    assign hit      = (32'(in_word.entry) == 32'(IDX));
    assign searched = (IDX >= 1) && (32'(IDX) < 32'(slice_count));
    assign is_top   = (32'(IDX) == 32'(slice_count));

    always_comb
    begin
        bound_next = bound_reg;
        word_next  = in_word;
        plane_next = in_plane;
        if (in_valid && in_word.func == FUNC_LOAD && hit)
        begin
            bound_next = in_word.bval;
        end
        if (in_valid && in_word.func == FUNC_MAP)
        begin
            if (searched && in_word.pos > {16'b0, bound_reg})
            begin
                plane_next = PLANE_W'(IDX);
            end
            if (is_top)
            begin
                word_next.beyond = (in_word.nxt > {17'b0, bound_reg});
            end
        end
    end

    // table entry: undefined until loaded
    always_ff @(posedge clk)
    begin
        bound_reg <= bound_next;
        word_reg  <= word_next;
        plane_reg <= plane_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;
    assign out_plane = plane_reg;

endmodule

`default_nettype wire

@@ rtl/core/zsra_index.sv @@
// Output stages: linear source index from plane, row and column, and the
// result register. Depends on zsra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module zsra_index #(
    parameter int PLANE_W = 8
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire zsra_pkg::chain_word_t    in_word,
    input  wire logic [PLANE_W-1:0]       in_plane,
    input  wire logic [zsra_pkg::XY_W-1:0] xy,
    output logic                          done,
    output zsra_pkg::result_t             result,
    output zsra_pkg::func_t               out_func
);
    import zsra_pkg::*;

    localparam int PROD_W = PLANE_W + XY_W;

    logic [PROD_W-1:0]  pxy_full;
    logic               t1_valid_reg;
    func_t              t1_func_reg;
    logic [INDEX_W-1:0] t1_pxy_reg;
    logic [INDEX_W-1:0] t1_rowcol_reg;
    logic [7:0]         t1_plane_reg;
    logic               t1_beyond_reg;
    logic               done_reg;
    result_t            result_reg;
    result_t            result_next;
    func_t              func_reg;

    assign pxy_full = {{XY_W{1'b0}}, in_plane} * {{PLANE_W{1'b0}}, xy};

    always_comb
    begin
        result_next = '0;
        if (t1_func_reg == FUNC_MAP)
        begin
            result_next.source_plane = t1_plane_reg;
            result_next.source_index = t1_pxy_reg + t1_rowcol_reg;
            result_next.beyond_top   = t1_beyond_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t1_func_reg   <= in_word.func;
        t1_pxy_reg    <= INDEX_W'(pxy_full);
        t1_rowcol_reg <= in_word.rowcol;
        t1_plane_reg  <= 8'(in_plane);
        t1_beyond_reg <= in_word.beyond;
        result_reg    <= result_next;
        func_reg      <= t1_func_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            t1_valid_reg <= in_valid;
            done_reg     <= t1_valid_reg;
        end
    end

    assign done     = done_reg;
    assign result   = result_reg;
    assign out_func = func_reg;

endmodule

`default_nettype wire

@@ rtl/core/z_slice_resample_address.sv @@
// Top level of the Z slice resample address block: register port, front
// multiply stages, the cell chain and the index stages. Depends on zsra_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes one word per cycle; busy stays low. Every word, load or map, flows
// through a row of MAX_SLICES+1 cells, one per boundary entry, so its result
// shows on done after two front stages, the cell row and two index stages.
// Loads write their entry as they pass the cell, so words see the table in
// the order they were issued. A result is held for one cycle only; the
// receiver must take it then. No clearing pass after reset: entries read
// before they are loaded give undefined results. Registers sit at byte
// addresses 0, 4, 8, 12 and should change only when no word is in flight.

module z_slice_resample_address #(
    parameter int MAX_SLICES  = zsra_pkg::MAX_SLICES_DEF,
    parameter int MAX_ROW_LEN = zsra_pkg::MAX_ROW_LEN_DEF,
    parameter int MAX_ROWS    = zsra_pkg::MAX_ROWS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire zsra_pkg::in_item_t item,
    output logic                    done,
    output zsra_pkg::result_t       result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import zsra_pkg::*;

    `include "z_slice_resample_address_macros.svh"

    localparam int PLANE_W = $clog2(MAX_SLICES);
    localparam int CELLS   = MAX_SLICES + 1;
    localparam int LAT     = MAX_SLICES + 5;

    localparam logic [10:0] X_RST = (1024 > MAX_ROW_LEN) ? 11'(MAX_ROW_LEN) : 11'd1024;
    localparam logic [10:0] Y_RST = (1024 > MAX_ROWS) ? 11'(MAX_ROWS) : 11'd1024;
    localparam logic [8:0]  S_RST = (256 > MAX_SLICES) ? 9'(MAX_SLICES) : 9'd256;

    // ---------------- configuration ----------------
    logic [31:0]     new_z_res_reg;
    logic [10:0]     x_points_reg;
    logic [10:0]     y_points_reg;
    logic [8:0]      slice_count_reg;
    logic [XY_W-1:0] xy_reg;
    logic            cfg_wr;
    reg_idx_t        cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            new_z_res_reg   <= 32'd256;
            x_points_reg    <= X_RST;
            y_points_reg    <= Y_RST;
            slice_count_reg <= S_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_NEW_Z_RES:
                    new_z_res_reg <= pwdata;
                REG_X_POINTS:
                    x_points_reg <= (32'(pwdata[10:0]) > 32'(MAX_ROW_LEN)) ?
                                    11'(MAX_ROW_LEN) : pwdata[10:0];
                REG_Y_POINTS:
                    y_points_reg <= (32'(pwdata[10:0]) > 32'(MAX_ROWS)) ?
                                    11'(MAX_ROWS) : pwdata[10:0];
                REG_SLICE_COUNT:
                    slice_count_reg <= (32'(pwdata[8:0]) > 32'(MAX_SLICES)) ?
                                       9'(MAX_SLICES) : pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_NEW_Z_RES:   prdata = new_z_res_reg;
            REG_X_POINTS:    prdata = {21'b0, x_points_reg};
            REG_Y_POINTS:    prdata = {21'b0, y_points_reg};
            REG_SLICE_COUNT: prdata = {23'b0, slice_count_reg};
            default:         prdata = '0;
        endcase
    end

    // slice size in voxels; registered, so it follows the registers in the next cycle
    always_ff @(posedge clk)
    begin
        xy_reg <= {11'b0, x_points_reg} * {11'b0, y_points_reg};
    end

    // ---------------- front stages ----------------
    logic               accept;
    logic               f1_valid_reg;
    func_t              f1_func_reg;
    logic [8:0]         f1_entry_reg;
    logic [31:0]        f1_bval_reg;
    logic [47:0]        f1_pos_reg;
    logic [INDEX_W-1:0] f1_rowx_reg;
    logic [9:0]         f1_col_reg;
    logic               f2_valid_reg;
    chain_word_t        f2_word_reg;
    chain_word_t        f2_word_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        f2_word_next.func   = f1_func_reg;
        f2_word_next.entry  = f1_entry_reg;
        f2_word_next.bval   = f1_bval_reg;
        f2_word_next.pos    = f1_pos_reg;
        f2_word_next.nxt    = {1'b0, f1_pos_reg} + {17'b0, new_z_res_reg};
        f2_word_next.rowcol = f1_rowx_reg + {18'b0, f1_col_reg};
        f2_word_next.beyond = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        f1_func_reg  <= item.func;
        f1_entry_reg <= item.entry;
        f1_bval_reg  <= item.boundary_value;
        f1_pos_reg   <= {32'b0, item.dest_slice} * {16'b0, new_z_res_reg};
        f1_rowx_reg  <= {18'b0, item.row} * {17'b0, x_points_reg};
        f1_col_reg   <= item.column;
        f2_word_reg  <= f2_word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= accept;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    // ---------------- cell row ----------------
    logic               link_valid [CELLS+1];
    chain_word_t        link_word  [CELLS+1];
    logic [PLANE_W-1:0] link_plane [CELLS+1];

    assign link_valid[0] = f2_valid_reg;
    assign link_word[0]  = f2_word_reg;
    assign link_plane[0] = '0;

    for (genvar k = 0; k < CELLS; k++)
    begin : g_cell
        zsra_cell #(
            .IDX     (k),
            .PLANE_W (PLANE_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .slice_count (slice_count_reg),
            .in_valid    (link_valid[k]),
            .in_word     (link_word[k]),
            .in_plane    (link_plane[k]),
            .out_valid   (link_valid[k+1]),
            .out_word    (link_word[k+1]),
            .out_plane   (link_plane[k+1])
        );
    end

    // ---------------- index stages ----------------
    func_t out_func;

    zsra_index #(
        .PLANE_W (PLANE_W)
    ) u_index (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (link_valid[CELLS]),
        .in_word  (link_word[CELLS]),
        .in_plane (link_plane[CELLS]),
        .xy       (xy_reg),
        .done     (done),
        .result   (result),
        .out_func (out_func)
    );

    // ---------------- checks ----------------
    `ZSRA_ASSERT_DELAY(a_fixed_latency, accept, LAT, done, "word lost or late in the chain")
    `ZSRA_ASSERT_IMPL(a_load_zero, done && out_func == FUNC_LOAD, result == '0, "load result not zero")
    `ZSRA_ASSERT_NEXT(a_tail_done, link_valid[CELLS], ##1 done, "chain output not delivered")

endmodule

`default_nettype wire
